[src/fit_pkg.sv]
// ----------------------------------------------------------------------------
// fit_pkg: shared types and constants of the flow ignore table
// Holds the table entry layout, hash multiplier, function and status codes.
// ----------------------------------------------------------------------------
package fit_pkg;

    localparam logic [31:0] HASH_MUL  = 32'd1021;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_CLIENT = 2'd1;
    localparam logic [1:0] DIR_SERVER = 2'd2;

    // One table entry as it sits in the entry memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] lo_ip;
        logic [31:0] hi_ip;
        logic [15:0] kport;
        logic [7:0]  proto;
        logic [31:0] ip1;
        logic [15:0] port1;
        logic [31:0] ip2;
        logic [15:0] port2;
        logic [1:0]  dir;
        logic [31:0] expiry;
        logic [15:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[src/fit_ram.sv]
// ----------------------------------------------------------------------------
// fit_ram: generic single-port RAM
// One read or write address per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module fit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[src/fit_hash.sv]
// ----------------------------------------------------------------------------
// fit_hash: iterative flow key hash
// Folds the key with three multiply-adds by 1021, one per cycle.
// ----------------------------------------------------------------------------
module fit_hash #(
    parameter int SET_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      lo_ip,
    input  logic [31:0]      hi_ip,
    input  logic [15:0]      kport,
    input  logic [7:0]       proto,
    output logic             done,
    output logic [SET_W-1:0] set_idx
);

    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic        done_reg;
    logic        done_next;

    always_comb
    begin
        h_next    = h_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            h_next    = 32'(lo_ip * fit_pkg::HASH_MUL) + hi_ip;
            step_next = 2'd1;
        end
        else if (step_reg == 2'd1)
        begin
            h_next    = 32'(h_reg * fit_pkg::HASH_MUL) + {16'd0, kport};
            step_next = 2'd2;
        end
        else if (step_reg == 2'd2)
        begin
            h_next    = 32'(h_reg * fit_pkg::HASH_MUL) + {24'd0, proto};
            step_next = 2'd0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end

    assign done    = done_reg;
    assign set_idx = h_reg[SET_W-1:0];

endmodule

[src/flow_ignore_table.sv]
// ----------------------------------------------------------------------------
// flow_ignore_table: hashed set-associative table of flows to ignore
// Adds flows and checks packets against them, with expiry and a prune sweep.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the entry memory and holds
// in_stall high, then takes items one at a time. An add that is not rejected
// hashes the key, probes the ways of its set one at a time (one memory port,
// one way per access), writes the entry back and loads the result.
// A check takes up to two such probes, then the prune walk, which steps past
// each empty entry and removes each expired entry that it meets.
// A finished result waits in the output register while the next item enters;
// the next transfer can be taken in the cycle after the result is loaded.
// ----------------------------------------------------------------------------
module flow_ignore_table #(
    parameter int TABLE_SETS  = 256,
    parameter int WAYS        = 4,
    parameter int PRUNE_LIMIT = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] ip_a,
    input  logic [15:0] port_a,
    input  logic [31:0] ip_b,
    input  logic [15:0] port_b,
    input  logic [7:0]  proto,
    input  logic [1:0]  dir_allowed,
    input  logic        always_flag,
    input  logic [15:0] timeout_secs,
    input  logic [31:0] now_secs,
    input  logic        from_client,
    input  logic        from_server,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [1:0]  ignore_dir
);

    // TABLE_SETS is taken as a power of two: the set is the low hash bits.
    localparam int ENTRIES = TABLE_SETS * WAYS;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SET_W   = $clog2(TABLE_SETS);
    localparam int WCNT_W  = $clog2(WAYS + 1);
    localparam int PCNT_W  = $clog2(PRUNE_LIMIT + 2);

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [WCNT_W-1:0] LAST_WAY = WCNT_W'(WAYS - 1);
    localparam logic [PCNT_W-1:0] PRUNE_MAX = PCNT_W'(PRUNE_LIMIT);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PCMP  = 4'd4;
    localparam logic [3:0] S_ADDW  = 4'd5;
    localparam logic [3:0] S_CHKW  = 4'd6;
    localparam logic [3:0] S_PRCK  = 4'd7;
    localparam logic [3:0] S_PRRD  = 4'd8;
    localparam logic [3:0] S_PRCMP = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // Control state.
    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W:0]   live_reg, live_next;
    logic [WCNT_W-1:0] way_reg, way_next;
    logic             second_reg, second_next;
    logic             free_found_reg, free_found_next;
    logic             hit_reg, hit_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             hash_go_reg, hash_go_next;

    // Item and working payload.
    logic             func_reg, func_next;
    logic [31:0]      ip_a_reg, ip_a_next;
    logic [15:0]      port_a_reg, port_a_next;
    logic [31:0]      ip_b_reg, ip_b_next;
    logic [15:0]      port_b_reg, port_b_next;
    logic [7:0]       proto_reg, proto_next;
    logic [1:0]       dir_reg, dir_next;
    logic [31:0]      now_reg, now_next;
    logic             fc_reg, fc_next;
    logic             fs_reg, fs_next;
    logic [31:0]      exp_val_reg, exp_val_next;
    logic [31:0]      lo_reg, lo_next;
    logic [31:0]      hi_reg, hi_next;
    logic [15:0]      kport_reg, kport_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    fit_pkg::entry_t  hit_ent_reg, hit_ent_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [1:0]       res_dir_reg, res_dir_next;
    logic [1:0]       status_reg, status_next;
    logic [1:0]       ignore_dir_reg, ignore_dir_next;

    // Memory port.
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    fit_pkg::entry_t  mem_wdata;
    fit_pkg::entry_t  mem_rdata;

    // Hash unit.
    logic             hash_start;
    logic             hash_done;
    logic [SET_W-1:0] hash_set;

    logic [32:0]      exp_sum;
    logic             in_accept;
    logic             out_free;
    logic             key_hit;
    logic             ent_expired;
    logic             hit_expired;
    logic             ep_match;
    logic             chk_ok;
    logic [15:0]      chk_count;
    logic             chk_drop;
    fit_pkg::entry_t  upd_ent;
    logic [IDX_W-1:0] ptr_inc;

    fit_ram #(
        .WIDTH (fit_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    fit_hash #(
        .SET_W (SET_W)
    ) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .lo_ip   (lo_reg),
        .hi_ip   (hi_reg),
        .kport   (kport_reg),
        .proto   (proto_reg),
        .done    (hash_done),
        .set_idx (hash_set)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ptr_inc   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;

    // The hash unit starts in the first cycle of the hash wait state, once the
    // key registers hold the key of this probe.
    assign hash_start = hash_go_reg;

    // The expiry of a new or refreshed entry saturates at all ones.
    assign exp_sum = {1'b0, now_secs} + {17'd0, timeout_secs};

    // Key compare against the entry just read from the memory.
    assign key_hit = mem_rdata.valid && (mem_rdata.lo_ip == lo_reg) &&
                     (mem_rdata.hi_ip == hi_reg) && (mem_rdata.kport == kport_reg) &&
                     (mem_rdata.proto == proto_reg);

    // An entry has expired when it carries a nonzero expiry that now has passed.
    assign ent_expired = (mem_rdata.expiry != '0) && (now_reg > mem_rdata.expiry);
    assign hit_expired = (hit_ent_reg.expiry != '0) && (now_reg > hit_ent_reg.expiry);

    // A packet matches the stored endpoints in either orientation, where a
    // stored port of zero matches any port.
    always_comb
    begin
        ep_match = ((hit_ent_reg.ip1 == ip_a_reg) && (hit_ent_reg.ip2 == ip_b_reg) &&
                    ((hit_ent_reg.port1 == port_a_reg) || (hit_ent_reg.port1 == '0)) &&
                    ((hit_ent_reg.port2 == port_b_reg) || (hit_ent_reg.port2 == '0))) ||
                   ((hit_ent_reg.ip2 == ip_a_reg) && (hit_ent_reg.ip1 == ip_b_reg) &&
                    ((hit_ent_reg.port2 == port_a_reg) || (hit_ent_reg.port2 == '0)) &&
                    ((hit_ent_reg.port1 == port_b_reg) || (hit_ent_reg.port1 == '0)));
        if ((hit_ent_reg.dir == fit_pkg::DIR_CLIENT) && !fc_reg)
        begin
            ep_match = 1'b0;
        end
        if ((hit_ent_reg.dir == fit_pkg::DIR_SERVER) && !fs_reg)
        begin
            ep_match = 1'b0;
        end
        chk_ok    = ep_match && (hit_ent_reg.count != '0) && !hit_expired;
        chk_count = chk_ok ? hit_ent_reg.count - 1'b1 : hit_ent_reg.count;
        chk_drop  = ((chk_count == '0) || hit_expired) && (hit_ent_reg.expiry != '0);
    end

    // Entry written back by an add: refresh, count up, or a fresh allocation.
    always_comb
    begin
        upd_ent = hit_ent_reg;
        if (hit_reg)
        begin
            if (hit_expired)
            begin
                upd_ent.ip1   = ip_a_reg;
                upd_ent.port1 = port_a_reg;
                upd_ent.ip2   = ip_b_reg;
                upd_ent.port2 = port_b_reg;
                upd_ent.dir   = dir_reg;
            end
            else if (hit_ent_reg.count != fit_pkg::COUNT_MAX)
            begin
                upd_ent.count = hit_ent_reg.count + 1'b1;
            end
        end
        else
        begin
            upd_ent.valid = 1'b1;
            upd_ent.lo_ip = lo_reg;
            upd_ent.hi_ip = hi_reg;
            upd_ent.kport = kport_reg;
            upd_ent.proto = proto_reg;
            upd_ent.ip1   = ip_a_reg;
            upd_ent.port1 = port_a_reg;
            upd_ent.ip2   = ip_b_reg;
            upd_ent.port2 = port_b_reg;
            upd_ent.dir   = dir_reg;
            upd_ent.count = 16'd1;
        end
        upd_ent.expiry = exp_val_reg;
    end

    // Memory address and write data for each state.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = ptr_reg;
        mem_wdata = mem_rdata;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_idx_reg;
                mem_wdata = '0;
            end
            S_PRD:
            begin
                mem_addr = base_reg + IDX_W'(way_reg);
            end
            S_ADDW:
            begin
                mem_we    = hit_reg || free_found_reg;
                mem_addr  = hit_reg ? hit_idx_reg : free_idx_reg;
                mem_wdata = upd_ent;
            end
            S_CHKW:
            begin
                mem_we          = 1'b1;
                mem_addr        = hit_idx_reg;
                mem_wdata       = hit_ent_reg;
                mem_wdata.count = chk_count;
                mem_wdata.valid = !chk_drop;
            end
            S_PRCMP:
            begin
                mem_we          = mem_rdata.valid && ent_expired;
                mem_addr        = ptr_reg;
                mem_wdata       = mem_rdata;
                mem_wdata.valid = 1'b0;
            end
            default:
            begin
                mem_addr = ptr_reg;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        ptr_next        = ptr_reg;
        live_next       = live_reg;
        way_next        = way_reg;
        second_next     = second_reg;
        free_found_next = free_found_reg;
        hit_next        = hit_reg;
        pcnt_next       = pcnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        func_next       = func_reg;
        ip_a_next       = ip_a_reg;
        port_a_next     = port_a_reg;
        ip_b_next       = ip_b_reg;
        port_b_next     = port_b_reg;
        proto_next      = proto_reg;
        dir_next        = dir_reg;
        now_next        = now_reg;
        fc_next         = fc_reg;
        fs_next         = fs_reg;
        exp_val_next    = exp_val_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        kport_next      = kport_reg;
        base_next       = base_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        hit_ent_next    = hit_ent_reg;
        res_status_next = res_status_reg;
        res_dir_next    = res_dir_reg;
        status_next     = status_reg;
        ignore_dir_next = ignore_dir_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next       = func;
                    ip_a_next       = ip_a;
                    port_a_next     = port_a;
                    ip_b_next       = ip_b;
                    port_b_next     = port_b;
                    proto_next      = proto;
                    dir_next        = dir_allowed;
                    now_next        = now_secs;
                    fc_next         = from_client;
                    fs_next         = from_server;
                    exp_val_next    = always_flag ? '0 :
                                      (exp_sum[32] ? fit_pkg::ALL_ONES : exp_sum[31:0]);
                    lo_next         = (ip_a < ip_b) ? ip_a : ip_b;
                    hi_next         = (ip_a < ip_b) ? ip_b : ip_a;
                    second_next     = 1'b0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    pcnt_next       = '0;
                    res_status_next = fit_pkg::ST_OK;
                    res_dir_next    = fit_pkg::DIR_NONE;
                    if (func == fit_pkg::FUNC_ADD)
                    begin
                        kport_next = (port_a != '0) ? port_a : port_b;
                        if (((port_a == '0) && (port_b == '0)) ||
                            (ip_a == '0) || (ip_a == fit_pkg::ALL_ONES) ||
                            (ip_b == '0) || (ip_b == fit_pkg::ALL_ONES))
                        begin
                            res_status_next = fit_pkg::ST_REJECT;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_HASH;
                        end
                    end
                    else
                    begin
                        // A check probes with the destination port first.
                        kport_next = port_b;
                        state_next = (live_reg == '0) ? S_DONE : S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                // The key registers were loaded on entry to this state.
                if (hash_done)
                begin
                    base_next       = IDX_W'(32'(hash_set) * WAYS);
                    way_next        = '0;
                    free_found_next = 1'b0;
                    state_next      = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                if (key_hit)
                begin
                    hit_next     = 1'b1;
                    hit_ent_next = mem_rdata;
                    hit_idx_next = base_reg + IDX_W'(way_reg);
                    state_next   = (func_reg == fit_pkg::FUNC_ADD) ? S_ADDW : S_CHKW;
                end
                else
                begin
                    if (!mem_rdata.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = base_reg + IDX_W'(way_reg);
                    end
                    if (way_reg == LAST_WAY)
                    begin
                        if (func_reg == fit_pkg::FUNC_ADD)
                        begin
                            state_next = S_ADDW;
                        end
                        else if (!second_reg)
                        begin
                            // Second probe with the source port.
                            second_next = 1'b1;
                            kport_next  = port_a_reg;
                            way_next    = '0;
                            state_next  = S_HASH;
                        end
                        else
                        begin
                            state_next = S_PRCK;
                        end
                    end
                    else
                    begin
                        way_next   = way_reg + 1'b1;
                        state_next = S_PRD;
                    end
                end
            end
            S_ADDW:
            begin
                if (hit_reg)
                begin
                    res_status_next = fit_pkg::ST_OK;
                end
                else if (free_found_reg)
                begin
                    res_status_next = fit_pkg::ST_OK;
                    live_next       = live_reg + 1'b1;
                end
                else
                begin
                    res_status_next = fit_pkg::ST_FULL;
                end
                state_next = S_DONE;
            end
            S_CHKW:
            begin
                res_dir_next = chk_ok ? hit_ent_reg.dir : fit_pkg::DIR_NONE;
                if (chk_drop && (live_reg != '0))
                begin
                    live_next = live_reg - 1'b1;
                end
                state_next = S_PRCK;
            end
            S_PRCK:
            begin
                if ((pcnt_reg == PRUNE_MAX) || (live_reg == '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PRRD;
                end
            end
            S_PRRD:
            begin
                state_next = S_PRCMP;
            end
            S_PRCMP:
            begin
                if (mem_rdata.valid)
                begin
                    if (ent_expired)
                    begin
                        live_next  = live_reg - 1'b1;
                        ptr_next   = ptr_inc;
                        pcnt_next  = pcnt_reg + 1'b1;
                        state_next = S_PRCK;
                    end
                    else
                    begin
                        // The pointer rests on the first live entry.
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_PRRD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    ignore_dir_next = res_dir_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Each probe starts the hash unit through a registered strobe that is high in
        // the first cycle of the hash wait state.
        hash_go_next = (state_next == S_HASH) && (state_reg != S_HASH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            ptr_reg        <= '0;
            live_reg       <= '0;
            way_reg        <= '0;
            second_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            pcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
            hash_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            ptr_reg        <= ptr_next;
            live_reg       <= live_next;
            way_reg        <= way_next;
            second_reg     <= second_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            pcnt_reg       <= pcnt_next;
            out_valid_reg  <= out_valid_next;
            hash_go_reg    <= hash_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        ip_a_reg       <= ip_a_next;
        port_a_reg     <= port_a_next;
        ip_b_reg       <= ip_b_next;
        port_b_reg     <= port_b_next;
        proto_reg      <= proto_next;
        dir_reg        <= dir_next;
        now_reg        <= now_next;
        fc_reg         <= fc_next;
        fs_reg         <= fs_next;
        exp_val_reg    <= exp_val_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        kport_reg      <= kport_next;
        base_reg       <= base_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        hit_ent_reg    <= hit_ent_next;
        res_status_reg <= res_status_next;
        res_dir_reg    <= res_dir_next;
        status_reg     <= status_next;
        ignore_dir_reg <= ignore_dir_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign ignore_dir = ignore_dir_reg;

endmodule

[src/fit_checker.sv]
// ----------------------------------------------------------------------------
// fit_checker: port-level checks of the flow ignore table
// Watches the handshakes and result codes seen on the top-level ports.
// ----------------------------------------------------------------------------
module fit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [1:0] ignore_dir
);

    // Items are worked one at a time, so a transfer closes the input.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(ignore_dir))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= fit_pkg::ST_FULL)
        else $error("undefined status code");

    // An add reports no direction and a check always reports ST_OK.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == fit_pkg::ST_OK) || (ignore_dir == fit_pkg::DIR_NONE))
        else $error("result carries both status and direction");

endmodule

bind flow_ignore_table fit_checker u_fit_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .ignore_dir (ignore_dir)
);
